### src/lkv_pkg.sv
// lkv_pkg: shared types and constants for the lru key-value cache
// used by lkv_cfg, lkv_store, lru_key_value_cache and the verif checker and test; no dependencies
package lkv_pkg;

	localparam int KEY_W  = 16;
	localparam int DATA_W = 16;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index as decoded from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_WRITE  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]  lookup_key;
		logic [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
	} resp_t;

endpackage

### src/lkv_cfg.sv
// lkv_cfg: apb register block holding the active capacity register
// depends on lkv_pkg
module lkv_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::APB_AW-1:0]  paddr,
	input  logic [lkv_pkg::APB_DW-1:0]  pwdata,
	output logic [lkv_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [lkv_pkg::CAP_W-1:0]   capacity
);

	logic [lkv_pkg::CAP_W-1:0] capacity_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == lkv_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (wr_en) begin
			capacity_q <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == lkv_pkg::REG_CAPACITY) begin
			prdata[lkv_pkg::CAP_W-1:0] = capacity_q;
		end
	end

	assign capacity = capacity_q;

endmodule

### src/lkv_store.sv
// lkv_store: entry array with parallel key match, recency ranks and update
// depends on lkv_pkg
module lkv_store #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  lkv_pkg::req_t              req,
	input  logic [lkv_pkg::CAP_W-1:0]  capacity,
	output lkv_pkg::resp_t             resp
);

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int WW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

	logic [ENTRIES-1:0]                valid_q;
	logic [lkv_pkg::KEY_W-1:0]         key_q   [ENTRIES];
	logic [lkv_pkg::DATA_W-1:0]        data_q  [ENTRIES];
	logic [RW-1:0]                     rank_q  [ENTRIES];
	logic [CW-1:0]                     filled_q;

	logic [ENTRIES-1:0]                match_oh;
	logic [ENTRIES-1:0]                free_oh;
	logic [ENTRIES-1:0]                lru_oh;
	logic [ENTRIES-1:0]                target_oh;
	logic                              hit;
	logic                              cap_ok;
	logic                              fill;
	logic                              is_write;
	logic [lkv_pkg::DATA_W-1:0]        hit_data;
	logic [CW-1:0]                     target_rank;
	logic [CW-1:0]                     old_rank;
	logic [CW-1:0]                     lru_rank;

	assign is_write = (req.mode == lkv_pkg::MODE_WRITE);
	assign lru_rank = filled_q - CW'(1);

	always_comb begin
		hit_data    = '0;
		target_rank = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			match_oh[j] = valid_q[j] && (key_q[j] == req.lookup_key);
			lru_oh[j]   = valid_q[j] && (CW'(rank_q[j]) == lru_rank);
			if (match_oh[j]) begin
				hit_data = hit_data | data_q[j];
			end
		end
		hit = |match_oh;
		free_oh = ~valid_q & (valid_q + ENTRIES'(1));
		cap_ok = (filled_q < CW'(ENTRIES)) &&
			((WW'(filled_q) < WW'(capacity)) || (filled_q == '0));
		fill = is_write && !hit && cap_ok;
		priority if (hit) begin
			target_oh = match_oh;
		end else if (fill) begin
			target_oh = free_oh;
		end else begin
			target_oh = lru_oh;
		end
		for (int j = 0; j < ENTRIES; j++) begin
			if (target_oh[j] && valid_q[j]) begin
				target_rank = target_rank | CW'(rank_q[j]);
			end
		end
		old_rank = fill ? filled_q : target_rank;
	end

	assign resp.hit        = hit;
	assign resp.read_value = (hit && !is_write) ? hit_data : '0;

	// control state: valid bits, ranks, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			filled_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (fire && (hit || is_write)) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (target_oh[j]) begin
					rank_q[j]  <= '0;
					valid_q[j] <= 1'b1;
				end else if (valid_q[j] && (CW'(rank_q[j]) < old_rank)) begin
					rank_q[j] <= rank_q[j] + RW'(1);
				end
			end
			if (fill) begin
				filled_q <= filled_q + CW'(1);
			end
		end
	end

	// payload: keys and values
	always_ff @(posedge clk) begin
		if (fire && is_write) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (target_oh[j]) begin
					key_q[j]  <= req.lookup_key;
					data_q[j] <= req.write_value;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q == CW'($countones(valid_q)))
		else $error("fill count disagrees with valid bits");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_oh))
		else $error("key matches more than one entry");

	a_lru_single: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q != '0) |-> $onehot(lru_oh))
		else $error("no unique least recent entry");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && fill) |=> (filled_q == $past(filled_q) + CW'(1)))
		else $error("fill did not grow the fill count");
`endif

endmodule

### src/lru_key_value_cache.sv
// lru_key_value_cache: top level, input register, store and result register
// depends on lkv_pkg, lkv_cfg, lkv_store
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: lookup_key, write_value
// m_*       out  m_tvalid/m_tready  tuser: hit; tdata: read_value
// apb       in   psel/penable       active_capacity at address 0
//
// one request per cycle sustained while m_tready high; input, then result register
// one pass of match, rank update and write between input and result register
// valid bits, ranks and fill count clear on reset; no clearing pass
// a stalled result holds while one more request waits in the input register
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // lookup_key, write_value
	input  logic [0:0]                  s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // read_value
	output logic [0:0]                  m_tuser,  // hit
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::APB_AW-1:0]  paddr,
	input  logic [lkv_pkg::APB_DW-1:0]  pwdata,
	output logic [lkv_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	logic                      valid_s1;
	lkv_pkg::req_t             req_s1;
	logic                      valid_s2;
	lkv_pkg::resp_t            resp_s2;
	lkv_pkg::resp_t            resp;
	logic                      advance;
	logic [lkv_pkg::CAP_W-1:0] capacity;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	lkv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	lkv_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.req      (req_s1),
		.capacity (capacity),
		.resp     (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.mode        <= s_tuser[0];
			req_s1.lookup_key  <= s_tdata[15:0];
			req_s1.write_value <= s_tdata[31:16];
		end
		if (advance) begin
			resp_s2 <= resp;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = resp_s2.read_value;
	assign m_tuser[0] = resp_s2.hit;

endmodule

### verif/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// lru_key_value_cache_checker: watches the request, result and apb channels of the cache,
// keeps its own copy of the entries and ranks, and compares every result in order
// depends on lkv_pkg
module lru_key_value_cache_checker #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [31:0]                s_tdata,  // lookup_key, write_value
	input  logic [0:0]                 s_tuser,  // mode
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [15:0]                m_tdata,  // read_value
	input  logic [0:0]                 m_tuser,  // hit
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lkv_pkg::APB_AW-1:0] paddr,
	input  logic [lkv_pkg::APB_DW-1:0] pwdata,
	input  logic                       pready,
	output int                         mismatches,
	output int                         pending
);

	localparam int RANK_W = $clog2(ENTRIES);
	localparam int FILL_W = $clog2(ENTRIES + 1);

	logic                       line_valid [ENTRIES];
	logic [lkv_pkg::KEY_W-1:0]  line_key   [ENTRIES];
	logic [lkv_pkg::DATA_W-1:0] line_data  [ENTRIES];
	logic [RANK_W-1:0]          line_rank  [ENTRIES];
	logic [FILL_W-1:0]          lines_used;
	logic [lkv_pkg::CAP_W-1:0]  capacity;
	lkv_pkg::resp_t             expected_resp [$];

	task automatic promote(input int idx);
		logic [RANK_W-1:0] old;
		old = line_rank[idx];
		for (int j = 0; j < ENTRIES; j++)
			if (line_valid[j] && j != idx && line_rank[j] < old)
				line_rank[j] = line_rank[j] + RANK_W'(1);
		line_rank[idx] = '0;
	endtask

	task automatic cache_access(input logic mode, input logic [lkv_pkg::KEY_W-1:0] key,
			input logic [lkv_pkg::DATA_W-1:0] value, output lkv_pkg::resp_t r);
		int hit_idx;
		int slot;
		int victim;
		int limit;
		hit_idx = -1;
		for (int j = 0; j < ENTRIES; j++)
			if (hit_idx < 0 && line_valid[j] && line_key[j] == key)
				hit_idx = j;
		r.hit = (hit_idx >= 0);
		r.read_value = '0;
		limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : int'(capacity);
		if (hit_idx >= 0) begin
			if (mode == lkv_pkg::MODE_LOOKUP)
				r.read_value = line_data[hit_idx];
			else
				line_data[hit_idx] = value;
			promote(hit_idx);
		end else if (mode == lkv_pkg::MODE_WRITE) begin
			if (int'(lines_used) < limit) begin
				slot = -1;
				for (int j = 0; j < ENTRIES; j++)
					if (slot < 0 && !line_valid[j])
						slot = j;
				if (slot >= 0) begin
					for (int j = 0; j < ENTRIES; j++)
						if (line_valid[j])
							line_rank[j] = line_rank[j] + RANK_W'(1);
					line_valid[slot] = 1'b1;
					line_key[slot] = key;
					line_data[slot] = value;
					line_rank[slot] = '0;
					lines_used = lines_used + FILL_W'(1);
				end
			end else if (lines_used > 0) begin
				// replace the least recently used entry
				victim = -1;
				for (int j = 0; j < ENTRIES; j++)
					if (line_valid[j] && (victim < 0 || line_rank[j] > line_rank[victim]))
						victim = j;
				line_key[victim] = key;
				line_data[victim] = value;
				promote(victim);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lkv_pkg::resp_t got;
		lkv_pkg::resp_t want;
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) begin
				line_valid[j] = 1'b0;
				line_key[j] = '0;
				line_data[j] = '0;
				line_rank[j] = '0;
			end
			lines_used = '0;
			capacity = lkv_pkg::CAP_RESET;
			expected_resp.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == lkv_pkg::REG_CAPACITY)
				capacity = pwdata[lkv_pkg::CAP_W-1:0];
			if (s_tvalid && s_tready) begin
				cache_access(s_tuser[0], s_tdata[lkv_pkg::KEY_W-1:0],
					s_tdata[lkv_pkg::KEY_W+lkv_pkg::DATA_W-1:lkv_pkg::KEY_W], want);
				expected_resp.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.read_value = m_tdata;
				if (expected_resp.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result transaction hit=%0d read_value=%h",
							$realtime, got.hit, got.read_value);
					mismatches++;
				end else begin
					want = expected_resp.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"%0t: result mismatch: expected hit=%0d read_value=%h,",
								" got hit=%0d read_value=%h"}, $realtime, want.hit,
								want.read_value, got.hit, got.read_value);
						mismatches++;
					end
				end
			end
			pending = expected_resp.size();
		end
	end

endmodule

### verif/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// lru_key_value_cache_test: clock, reset, request and apb stimulus for the cache, and the verdict
// depends on lkv_pkg, lru_key_value_cache and lru_key_value_cache_checker
module lru_key_value_cache_test;

	localparam int ENTRIES = 16;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 195;
	localparam int POOL_MAX = 24;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [31:0]                s_tdata = '0;  // lookup_key, write_value
	logic [0:0]                 s_tuser = '0;  // mode
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [15:0]                m_tdata;       // read_value
	logic [0:0]                 m_tuser;       // hit
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [lkv_pkg::APB_AW-1:0] paddr = '0;
	logic [lkv_pkg::APB_DW-1:0] pwdata = '0;
	logic [lkv_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	int                         mismatches;
	int                         pending;
	logic                       steady = 1'b0;
	logic [lkv_pkg::KEY_W-1:0]  key_pool [POOL_MAX];
	int                         pool_size;
	logic [lkv_pkg::CAP_W-1:0]  phase_caps [PHASES] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0,
		5'd17, 5'd2, 5'd8, 5'd12, 5'd16};

	lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	lru_key_value_cache_checker #(.ENTRIES(ENTRIES)) result_check (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.mismatches, .pending
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= steady || $urandom_range(99) >= 13;

	task automatic send(input logic mode, input logic [lkv_pkg::KEY_W-1:0] key,
			input logic [lkv_pkg::DATA_W-1:0] value);
		if (!steady && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {value, key};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [lkv_pkg::APB_AW-1:0] addr,
			input logic [lkv_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
		logic [lkv_pkg::APB_DW-1:0] value;
		drain;
		// a write to the unused register index must leave the capacity alone
		if ($urandom_range(1)) begin
			write_reg({~lkv_pkg::REG_CAPACITY, 2'b00}, $urandom);
			@(posedge clk);
		end
		value = $urandom;
		value[lkv_pkg::CAP_W-1:0] = cap;
		write_reg({lkv_pkg::REG_CAPACITY, 2'b00}, value);
	endtask

	initial begin
		int eff;
		logic [lkv_pkg::KEY_W-1:0] key;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, key and value extremes, update in place, miss on lookup
		send(lkv_pkg::MODE_LOOKUP, 16'h0000, 16'hFFFF);
		send(lkv_pkg::MODE_WRITE, 16'h0000, 16'hFFFF);
		send(lkv_pkg::MODE_WRITE, 16'hFFFF, 16'h0000);
		send(lkv_pkg::MODE_LOOKUP, 16'hFFFF, 16'hA5A5);
		send(lkv_pkg::MODE_LOOKUP, 16'h0000, 16'h0000);
		send(lkv_pkg::MODE_WRITE, 16'h0000, 16'h5A5A);
		send(lkv_pkg::MODE_LOOKUP, 16'h0000, 16'hFFFF);
		send(lkv_pkg::MODE_LOOKUP, 16'h1234, 16'hFFFF);
		// capacity lowered below the fill
		set_capacity(5'd1);
		send(lkv_pkg::MODE_WRITE, 16'h0101, 16'h1111);
		send(lkv_pkg::MODE_LOOKUP, 16'hFFFF, 16'h0000);
		send(lkv_pkg::MODE_LOOKUP, 16'h0000, 16'h0000);
		send(lkv_pkg::MODE_WRITE, 16'h0000, 16'h2222);
		// capacity zero behaves as one
		set_capacity(5'd0);
		send(lkv_pkg::MODE_WRITE, 16'h0202, 16'h3333);
		send(lkv_pkg::MODE_LOOKUP, 16'h0101, 16'h0000);
		send(lkv_pkg::MODE_LOOKUP, 16'h0202, 16'h0000);
		// capacity above the entry count
		set_capacity(5'd31);
		send(lkv_pkg::MODE_WRITE, 16'h8000, 16'h8000);
		send(lkv_pkg::MODE_WRITE, 16'h7FFF, 16'h7FFF);
		send(lkv_pkg::MODE_LOOKUP, 16'h0202, 16'h0000);
		send(lkv_pkg::MODE_LOOKUP, 16'h8000, 16'h0000);

		for (int p = 0; p < PHASES; p++) begin
			set_capacity(p == PHASES - 2 ? lkv_pkg::CAP_W'($urandom_range(31))
				: phase_caps[p]);
			steady <= (p == 3);
			eff = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > ENTRIES) ? ENTRIES
				: int'(phase_caps[p]);
			pool_size = (eff + 4 > POOL_MAX) ? POOL_MAX : eff + 4;
			for (int k = 0; k < POOL_MAX; k++)
				key_pool[k] = lkv_pkg::KEY_W'($urandom);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				key = ($urandom_range(99) < 15) ? lkv_pkg::KEY_W'($urandom)
					: key_pool[$urandom_range(pool_size - 1)];
				send(logic'($urandom_range(1)), key, lkv_pkg::DATA_W'($urandom));
			end
		end

		drain;
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("** lru_key_value_cache: PASSED **");
		else
			$display("** lru_key_value_cache: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** lru_key_value_cache: FAILED **");
		$finish;
	end

endmodule
